[src/lsoe_pkg.sv]
// Package for the line sensor offset estimator: constants, codes, the
// controller/datapath interface structs and the sine table generator.
// No dependencies.
`default_nettype none
package lsoe_pkg;

	localparam int GROUP_SIZE_DEF   = 8;
	localparam int SINE_ENTRIES_DEF = 1024;

	localparam int SMP_W = 12;	// ADC sample and average width
	localparam int DIV_NW = 44;	// divider dividend and quotient width
	localparam int DIV_DW = 30;	// divider divisor and remainder width

	localparam int PHASE_PER_UNIT = 10430;
	localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
	localparam longint unsigned TAYLOR_DIV [5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_SUM_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_SIDE_GAIN     = 3'd1;
	localparam logic [2:0] REG_SWITCH_LEVEL  = 3'd2;
	localparam logic [2:0] REG_OUTPUT_LIMIT  = 3'd3;
	localparam logic [2:0] REG_ANGLE_BIAS    = 3'd4;
	localparam logic [2:0] REG_ANGLE_SCALE   = 3'd5;

	// Divider operations.
	localparam logic [1:0] OP_FRC = 2'd0;
	localparam logic [1:0] OP_SID = 2'd1;
	localparam logic [1:0] OP_MID = 2'd2;

	typedef struct packed {
		logic [12:0]        sum_threshold;
		logic [14:0]        side_gain;
		logic [14:0]        switch_level;
		logic [14:0]        output_limit;
		logic signed [15:0] angle_bias;
		logic [7:0]         angle_scale;
	} lsoe_cfg_t;

	typedef struct packed {
		logic       in_ready;
		logic       div_start;
		logic [1:0] op;
		logic       cap_div;
		logic       cap_avg;
		logic       cap_phase;
		logic       cap_idx;
		logic       cap_rom;
		logic       cap_sq;
		logic       cap_base;
		logic       set_base;
		logic       clr_mid;
		logic       load_out;
	} lsoe_cmd_t;

	typedef struct packed {
		logic grp_last;
		logic close;
		logic snap_cal;
		logic div_done;
		logic mid_zero;
		logic out_free;
	} lsoe_sts_t;

	// Sine of a Q24 fraction of a period, as Q15 in -32768..32768.
	// Odd Taylor series up to x^11 in Q30 over the folded first quadrant.
	function automatic logic signed [16:0] sine_of_phase(input longint unsigned ph);
		longint unsigned f;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint s;
		longint q;
		logic neg;
		f = ph;
		neg = 1'b0;
		if (f >= 64'd8388608) begin
			neg = 1'b1;
			f = f - 64'd8388608;
		end
		if (f > 64'd4194304) begin
			f = 64'd8388608 - f;
		end
		x = (f * TWO_PI_Q30) >> 24;
		x2 = (x * x) >> 30;
		t = x;
		s = longint'(x);
		for (int k = 0; k < 5; k++) begin
			t = ((t * x2) >> 30) / TAYLOR_DIV[k];
			if ((k % 2) == 0) s = s - longint'(t);
			else s = s + longint'(t);
		end
		if (s < 0) s = 0;
		q = (s + 64'sd16384) / 64'sd32768;
		return neg ? 17'(-q) : 17'(q);
	endfunction

endpackage
`default_nettype wire

[src/lsoe_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, unsigned.
// Uses lsoe_pkg for default widths.
`default_nettype none
module lsoe_div #(
	parameter int NW = lsoe_pkg::DIV_NW,
	parameter int DW = lsoe_pkg::DIV_DW
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [NW-1:0]      quotient
);
	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dsr_q;
	logic [DW:0]   shifted;
	logic [DW:0]   diff;
	logic [DW-1:0] rem_d;

	assign shifted = {rem_q, quo_q[NW-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign rem_d   = diff[DW] ? shifted[DW-1:0] : diff[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_d;
			quo_q <= {quo_q[NW-2:0], ~diff[DW]};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

[src/lsoe_ctrl.sv]
// Sequencer for the offset estimator: steps the datapath through the
// averages, sine lookup, scaling and both ratios. Uses lsoe_pkg.
`default_nettype none
module lsoe_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lsoe_pkg::lsoe_sts_t sts,
	output lsoe_pkg::lsoe_cmd_t     cmd
);
	import lsoe_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_AVG  = 4'd1;
	localparam logic [3:0] S_SETB = 4'd2;
	localparam logic [3:0] S_GO   = 4'd3;
	localparam logic [3:0] S_WAIT = 4'd4;
	localparam logic [3:0] S_PHM  = 4'd5;
	localparam logic [3:0] S_IXM  = 4'd6;
	localparam logic [3:0] S_ROM  = 4'd7;
	localparam logic [3:0] S_SQ   = 4'd8;
	localparam logic [3:0] S_BAS  = 4'd9;
	localparam logic [3:0] S_MCK  = 4'd10;
	localparam logic [3:0] S_FIN  = 4'd11;

	logic [3:0] state_q, state_d;
	logic [1:0] op_q, op_d;

	always_comb begin
		cmd = '0;
		cmd.op = op_q;
		cmd.in_ready = !sts.grp_last || (state_q == S_IDLE);
		state_d = state_q;
		op_d = op_q;
		case (state_q)
			S_IDLE: begin
				if (sts.close) begin
					state_d = S_AVG;
				end
			end
			S_AVG: begin
				cmd.cap_avg = 1'b1;
				state_d = sts.snap_cal ? S_SETB : S_PHM;
			end
			S_SETB: begin
				cmd.set_base = 1'b1;
				state_d = S_IDLE;
			end
			S_GO: begin
				cmd.div_start = 1'b1;
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (sts.div_done) begin
					cmd.cap_div = 1'b1;
					case (op_q)
						OP_FRC: state_d = S_IXM;
						OP_SID: state_d = S_MCK;
						default: state_d = S_FIN;
					endcase
				end
			end
			S_PHM: begin
				cmd.cap_phase = 1'b1;
				op_d = OP_FRC;
				state_d = S_GO;
			end
			S_IXM: begin
				cmd.cap_idx = 1'b1;
				state_d = S_ROM;
			end
			S_ROM: begin
				cmd.cap_rom = 1'b1;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.cap_sq = 1'b1;
				state_d = S_BAS;
			end
			S_BAS: begin
				cmd.cap_base = 1'b1;
				op_d = OP_SID;
				state_d = S_GO;
			end
			S_MCK: begin
				if (sts.mid_zero) begin
					cmd.clr_mid = 1'b1;
					state_d = S_FIN;
				end else begin
					op_d = OP_MID;
					state_d = S_GO;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_FRC;
		end else begin
			state_q <= state_d;
			op_q <= op_d;
		end
	end
endmodule
`default_nettype wire

[src/lsoe_datapath.sv]
// Datapath of the offset estimator: group accumulators, snapshot, shared
// divider, sine table, scaling multipliers and output register.
// Uses lsoe_pkg and lsoe_div.
`default_nettype none
module lsoe_datapath #(
	parameter int GROUP_SIZE   = lsoe_pkg::GROUP_SIZE_DEF,
	parameter int SINE_ENTRIES = lsoe_pkg::SINE_ENTRIES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lsoe_pkg::lsoe_cfg_t cfg,
	input  wire lsoe_pkg::lsoe_cmd_t cmd,
	output lsoe_pkg::lsoe_sts_t      sts,
	input  wire logic                in_valid,
	input  wire logic                cmd_in,
	input  wire logic [11:0]         left_sample,
	input  wire logic [11:0]         middle_sample,
	input  wire logic [11:0]         right_sample,
	input  wire logic signed [15:0]  tilt_angle,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [15:0]       offset,
	output logic [11:0]              left_avg,
	output logic [11:0]              middle_avg,
	output logic [11:0]              right_avg,
	output logic                     side_chosen
);
	import lsoe_pkg::*;

	localparam int AW = SMP_W + $clog2(GROUP_SIZE);
	localparam int CW = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
	localparam int EW = $clog2(SINE_ENTRIES + 1);
	localparam int IW = $clog2(SINE_ENTRIES);
	localparam int XW = 24 + EW;
	// Averages by reciprocal multiplication, exact for every group sum.
	localparam int RS = AW + $clog2(GROUP_SIZE);
	localparam int KW = AW + 2;
	localparam int MW = AW + KW;
	localparam longint unsigned RK =
		((64'd1 << RS) + 64'(GROUP_SIZE) - 64'd1) / 64'(GROUP_SIZE);
	localparam logic signed [15:0] PH_K = 16'(PHASE_PER_UNIT);

	// Constant sine table, one entry per step of the period.
	logic signed [16:0] sine_rom [SINE_ENTRIES];
	for (genvar gi = 0; gi < SINE_ENTRIES; gi++) begin : g_rom
		localparam longint unsigned PH = (64'(gi) << 24) / SINE_ENTRIES;
		assign sine_rom[gi] = sine_of_phase(PH);
	end

	// Group accumulation.
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] acc_l_q, acc_m_q, acc_r_q;
	logic [AW-1:0] sum_l, sum_m, sum_r;
	logic [AW-1:0] snap_l_q, snap_m_q, snap_r_q;
	logic          snap_cal_q;
	logic signed [15:0] snap_tilt_q;
	logic last, beat;

	assign last  = (cnt_q == CW'(GROUP_SIZE - 1));
	assign beat  = in_valid && cmd.in_ready;
	assign sum_l = acc_l_q + AW'(left_sample);
	assign sum_m = acc_m_q + AW'(middle_sample);
	assign sum_r = acc_r_q + AW'(right_sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			acc_l_q <= '0;
			acc_m_q <= '0;
			acc_r_q <= '0;
		end else if (beat) begin
			if (last) begin
				cnt_q <= '0;
				acc_l_q <= '0;
				acc_m_q <= '0;
				acc_r_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
				acc_l_q <= sum_l;
				acc_m_q <= sum_m;
				acc_r_q <= sum_r;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat && last) begin
			snap_l_q <= sum_l;
			snap_m_q <= sum_m;
			snap_r_q <= sum_r;
			snap_cal_q <= cmd_in;
			snap_tilt_q <= tilt_angle;
		end
	end

	// Working registers.
	logic [11:0] l_q, m_q, r_q, mbase_q;
	logic signed [31:0] phase_q;
	logic signed [30:0] frac_q;
	logic [IW-1:0] idx_q;
	logic signed [16:0] sine_q;
	logic [17:0] sq_q;
	logic [29:0] base_q;
	logic [14:0] side_mag_q, mid_q;
	logic side_neg_q;

	// Divider operand selection.
	logic [DIV_NW-1:0] dvd;
	logic [DIV_DW-1:0] dvs;
	logic              div_done;
	logic [DIV_NW-1:0] quo;
	logic [31:0] phase_mag;
	logic [7:0]  scale;
	logic [11:0] lr_diff;
	logic [26:0] side_num;
	logic [29:0] mq;

	assign phase_mag = phase_q[31] ? 32'(-phase_q) : 32'(phase_q);
	assign scale     = (cfg.angle_scale == 8'd0) ? 8'd1 : cfg.angle_scale;
	assign lr_diff   = (r_q >= l_q) ? (r_q - l_q) : (l_q - r_q);
	assign side_num  = 27'(cfg.side_gain) * 27'(lr_diff);
	assign mq        = 30'(m_q) << 15;

	always_comb begin
		case (cmd.op)
			OP_FRC: begin
				dvd = DIV_NW'(phase_mag);
				dvs = DIV_DW'(scale);
			end
			OP_SID: begin
				dvd = DIV_NW'(side_num);
				dvs = DIV_DW'(14'(l_q) + 14'(r_q) + 14'd1);
			end
			default: begin
				dvd = DIV_NW'(base_q - mq) << 15;
				dvs = base_q + 30'd32768;
			end
		endcase
	end

	lsoe_div #(
		.NW(DIV_NW),
		.DW(DIV_DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (quo)
	);

	// Multiplier stages, each followed by a register.
	logic [MW-1:0] avg_l, avg_m, avg_r;
	logic signed [16:0] d;
	logic signed [31:0] ph_prod;
	logic [XW-1:0] ix_prod;
	logic [17:0] g_sum;
	logic [33:0] gg;

	assign avg_l   = MW'(snap_l_q) * MW'(RK);
	assign avg_m   = MW'(snap_m_q) * MW'(RK);
	assign avg_r   = MW'(snap_r_q) * MW'(RK);
	assign d       = 17'(cfg.angle_bias) - 17'(snap_tilt_q);
	assign ph_prod = 32'(d) * 32'(PH_K);
	// The phase modulo one period is its low 24 bits; scaling that by the
	// table size gives the entry directly.
	assign ix_prod = XW'(frac_q[23:0]) * XW'(SINE_ENTRIES);
	assign g_sum   = 18'(sine_q) + 18'd32768;
	assign gg      = 34'(g_sum[16:0]) * 34'(g_sum[16:0]);

	always_ff @(posedge clk) begin
		if (cmd.cap_avg) begin
			l_q <= avg_l[RS +: SMP_W];
			m_q <= avg_m[RS +: SMP_W];
			r_q <= avg_r[RS +: SMP_W];
		end
		if (cmd.cap_div) begin
			case (cmd.op)
				OP_FRC: frac_q <= phase_q[31] ? -31'(quo) : 31'(quo);
				OP_SID: begin
					side_mag_q <= quo[14:0];
					side_neg_q <= (r_q < l_q) && (quo[14:0] != 15'd0);
				end
				default: mid_q <= quo[14:0];
			endcase
		end
		if (cmd.cap_phase) phase_q <= ph_prod;
		if (cmd.cap_idx) idx_q <= ix_prod[24 +: IW];
		if (cmd.cap_rom) sine_q <= sine_rom[idx_q];
		if (cmd.cap_sq) sq_q <= gg[32:15];
		if (cmd.cap_base) base_q <= 30'(mbase_q) * 30'(sq_q);
		if (cmd.clr_mid) mid_q <= '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbase_q <= '0;
		end else if (cmd.set_base) begin
			mbase_q <= m_q;
		end
	end

	// Selection and clamp.
	logic [12:0] lr_sum;
	logic chosen;
	logic signed [16:0] side_s, mid_s, res, lim, res_c;

	assign lr_sum = 13'(l_q) + 13'(r_q);
	assign chosen = (lr_sum > cfg.sum_threshold) && (mid_q < cfg.switch_level);
	assign side_s = side_neg_q ? -17'(side_mag_q) : 17'(side_mag_q);
	assign mid_s  = side_neg_q ? -17'(mid_q) : 17'(mid_q);
	assign res    = chosen ? side_s : mid_s;
	assign lim    = 17'(cfg.output_limit);

	always_comb begin
		if (res > lim) res_c = lim;
		else if (res < -lim) res_c = -lim;
		else res_c = res;
	end

	// Output register.
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			offset <= res_c[15:0];
			left_avg <= l_q;
			middle_avg <= m_q;
			right_avg <= r_q;
			side_chosen <= chosen;
		end
	end

	assign out_valid = out_valid_q;

	assign sts.grp_last = last;
	assign sts.close    = beat && last;
	assign sts.snap_cal = snap_cal_q;
	assign sts.div_done = div_done;
	assign sts.mid_zero = mq > base_q;
	assign sts.out_free = out_free;
endmodule
`default_nettype wire

[src/line_sensor_offset_estimator.sv]
// Top level of the line sensor offset estimator: configuration registers,
// sequencer and datapath. Uses lsoe_pkg, lsoe_ctrl and lsoe_datapath.
//
// Usage
// Sample beats (cmd, left/middle/right samples, tilt) arrive on a valid/ready
// input channel. Every GROUP_SIZE beats form a group whose truncated
// averages are taken. A group closing with cmd = 1 stores the middle average
// as the reference base and produces nothing. A group closing with cmd = 0
// produces one result beat: a clamped Q1.15 offset, the three averages and
// a flag telling whether the side ratio was chosen.
// Processing: the averages come from reciprocal multiplications and the
// table index from a multiply, so the shared radix-2 divider, one quotient
// bit per cycle over 44 bits, runs only for the sine phase and the side and
// middle ratios. The middle ratio is set to zero without a division when
// the scaled middle average exceeds the scaled base. A calibrate group only
// takes the averages and stores the base. Beats of the next group are
// accepted while a group is processed; only its closing beat waits until
// the sequencer is idle again.
// Stalls: the result sits in an output register until taken. While it
// waits, a new result is held back in the sequencer's final step.
// Reset: arst_n clears the accumulators, the base and the valid flag and
// loads the register defaults. Configuration is written through cfg_we,
// cfg_index and cfg_data with no wait; indexes beyond the list are ignored.
`default_nettype none
module line_sensor_offset_estimator #(
	parameter int GROUP_SIZE   = lsoe_pkg::GROUP_SIZE_DEF,
	parameter int SINE_ENTRIES = lsoe_pkg::SINE_ENTRIES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               cmd,
	input  wire logic [11:0]        left_sample,
	input  wire logic [11:0]        middle_sample,
	input  wire logic [11:0]        right_sample,
	input  wire logic signed [15:0] tilt_angle,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      offset,
	output logic [11:0]             left_avg,
	output logic [11:0]             middle_avg,
	output logic [11:0]             right_avg,
	output logic                    side_chosen,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);
	import lsoe_pkg::*;

	lsoe_cfg_t cfg_q;
	lsoe_cmd_t ctl_cmd;
	lsoe_sts_t dp_sts;

	// Configuration registers with their defaults.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sum_threshold <= 13'd100;
			cfg_q.side_gain <= 15'd19661;
			cfg_q.switch_level <= 15'd6554;
			cfg_q.output_limit <= 15'd19661;
			cfg_q.angle_bias <= 16'sd3200;
			cfg_q.angle_scale <= 8'd60;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SUM_THRESHOLD: cfg_q.sum_threshold <= cfg_data[12:0];
				REG_SIDE_GAIN: cfg_q.side_gain <= cfg_data[14:0];
				REG_SWITCH_LEVEL: cfg_q.switch_level <= cfg_data[14:0];
				REG_OUTPUT_LIMIT: cfg_q.output_limit <= cfg_data[14:0];
				REG_ANGLE_BIAS: cfg_q.angle_bias <= cfg_data;
				REG_ANGLE_SCALE: cfg_q.angle_scale <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	lsoe_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (dp_sts),
		.cmd   (ctl_cmd)
	);

	lsoe_datapath #(
		.GROUP_SIZE  (GROUP_SIZE),
		.SINE_ENTRIES(SINE_ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (ctl_cmd),
		.sts          (dp_sts),
		.in_valid     (in_valid),
		.cmd_in       (cmd),
		.left_sample  (left_sample),
		.middle_sample(middle_sample),
		.right_sample (right_sample),
		.tilt_angle   (tilt_angle),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.offset       (offset),
		.left_avg     (left_avg),
		.middle_avg   (middle_avg),
		.right_avg    (right_avg),
		.side_chosen  (side_chosen)
	);

	assign in_ready = ctl_cmd.in_ready;
endmodule
`default_nettype wire

[src/lsoe_checker.sv]
// Port-level checks for the line sensor offset estimator, attached to the
// top level by the bind statement at the end. No package dependency.
`default_nettype none
module lsoe_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [15:0] offset,
	input wire logic [11:0]        left_avg,
	input wire logic [11:0]        right_avg
);
	// A stalled result beat keeps its offset.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(offset))
		else $error("result beat changed while stalled");

	// The clamp keeps the offset symmetric, so the most negative code never shows.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> offset != 16'sh8000)
		else $error("offset outside the symmetric range");

	// With the right average not below the left one the offset is never negative.
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (right_avg >= left_avg) |-> !offset[15])
		else $error("offset sign disagrees with the side averages");
endmodule

bind line_sensor_offset_estimator lsoe_checker u_lsoe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.offset   (offset),
	.left_avg (left_avg),
	.right_avg(right_avg)
);
`default_nettype wire
